// ----- design/scc_pkg.sv -----
// Shared types and constants for the segment contour chainer.
// Depends on nothing; scc_cell and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    localparam int unsigned SEGMENTS_DEF = 256;
    localparam int unsigned COORD_BITS   = 24;
    localparam int unsigned LEFT_BITS    = 9;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PULL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        t_point a;
        t_point b;
    } t_seg;

    typedef struct packed {
        logic shift;
        logic clear;
        logic wr;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]                   command;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
    } t_cmd_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         point_valid;
        logic                         contour_done;
        logic                         contour_open;
        logic                         table_empty;
        logic                         load_rejected;
        logic [LEFT_BITS-1:0]         segments_left;
    } t_res_item;

endpackage

`default_nettype wire

// ----- design/scc_stream_if.sv -----
// Valid/ready channel carrying one item of a chosen payload type.
// Used by the top level for its command and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface scc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/scc_cell.sv -----
// One cell of the segment ring: a stored segment and its live mark.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire scc_pkg::t_cell_ctl    i_ctl,
    input  wire scc_pkg::t_seg         i_wr_seg,
    input  wire scc_pkg::t_seg         i_nb_seg,
    input  wire logic                  i_nb_live,
    output scc_pkg::t_seg              o_seg,
    output logic                       o_live
);
    import scc_pkg::*;

    t_seg r_seg;
    logic r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_ctl.clear) begin
            r_live <= 1'b0;
        end else if (i_ctl.wr) begin
            r_live <= 1'b1;
        end else if (i_ctl.shift) begin
            r_live <= i_nb_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_seg <= i_wr_seg;
        end else if (i_ctl.shift) begin
            r_seg <= i_nb_seg;
        end
    end

    assign o_seg  = r_seg;
    assign o_live = r_live;

endmodule

`default_nettype wire

// ----- design/segment_contour_chainer.sv -----
// Top level of the segment contour chainer: control, ring of scc_cell, result register.
// Depends on scc_pkg, scc_stream_if and scc_cell.
//
//   channel  dir  payload      meaning
//   i_cmd    in   t_cmd_item   load, pull or clear
//   o_res    out  t_res_item   one result for each command
//
// Load, clear and unused commands, and a pull that closes a contour, write their result
// straight from the idle state; any other pull rotates the whole ring once through its head
// cell and then writes its result. Reset clears every live mark at once, so no sweep follows it.
// A command is taken only while the controller is idle and the output register is empty or is
// being read in the same cycle, so a result that is not taken holds off the next command.
`timescale 1ns / 1ps
`default_nettype none

module segment_contour_chainer #(
    parameter int unsigned SEGMENTS = scc_pkg::SEGMENTS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scc_stream_if.sink   i_cmd,
    scc_stream_if.source o_res
);
    import scc_pkg::*;

    localparam int unsigned IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(SEGMENTS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    t_state          r_state;
    logic [IW-1:0]   r_k;
    logic [CW-1:0]   r_slot;
    logic [CW-1:0]   r_cnt;
    t_point          r_start;
    t_point          r_cur;
    logic            r_in_contour;
    logic            r_closing;
    logic            r_found;
    t_seg            r_hit;
    t_res_item       r_out;
    logic            r_out_v;
    t_res_item       n_out;
    logic            n_out_v;

    t_seg            w_seg  [SEGMENTS];
    logic            w_live [SEGMENTS];
    t_cmd_item       w_cmd;
    t_seg            w_wr_seg;
    logic            w_out_free;
    logic            w_accept;
    logic            w_load_wr;
    logic            w_clear;
    logic            w_hit;
    logic            w_live_wrap;
    logic            w_match_a;
    t_point          w_next;
    logic            w_res_load;

    assign w_cmd      = i_cmd.data;
    assign w_out_free = !r_out_v || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_load_wr  = w_accept && (w_cmd.command == CMD_LOAD) && (r_slot < CW'(SEGMENTS));
    assign w_clear    = w_accept && (w_cmd.command == CMD_CLEAR);

    assign w_wr_seg.a.x = w_cmd.first_x;
    assign w_wr_seg.a.y = w_cmd.first_y;
    assign w_wr_seg.b.x = w_cmd.second_x;
    assign w_wr_seg.b.y = w_cmd.second_y;

    // The head cell holds segment r_k during a rotation; the first qualifying one is taken
    // and goes back into the ring with its live mark cleared.
    assign w_hit = (r_state == ST_SCAN) && !r_found && w_live[0] &&
                   (!r_in_contour || (w_seg[0].a == r_cur) || (w_seg[0].b == r_cur));
    assign w_live_wrap = w_live[0] && !w_hit;

    assign w_match_a = (r_hit.a == r_cur);
    assign w_next    = w_match_a ? r_hit.b : r_hit.a;

    for (genvar gi = 0; gi < SEGMENTS; gi++) begin : g_cell
        t_cell_ctl w_ctl;
        t_seg      w_nb_seg;
        logic      w_nb_live;

        assign w_ctl.shift = (r_state == ST_SCAN);
        assign w_ctl.clear = w_clear;
        assign w_ctl.wr    = w_load_wr && (r_slot[IW-1:0] == IW'(gi));

        if (gi == SEGMENTS - 1) begin : g_wrap
            assign w_nb_seg  = w_seg[0];
            assign w_nb_live = w_live_wrap;
        end else begin : g_link
            assign w_nb_seg  = w_seg[gi+1];
            assign w_nb_live = w_live[gi+1];
        end

        scc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_wr_seg  (w_wr_seg),
            .i_nb_seg  (w_nb_seg),
            .i_nb_live (w_nb_live),
            .o_seg     (w_seg[gi]),
            .o_live    (w_live[gi])
        );
    end

    always_comb begin
        n_out               = '0;
        n_out.segments_left = LEFT_BITS'(r_cnt);
        w_res_load          = 1'b0;
        if ((r_state == ST_IDLE) && w_accept) begin
            case (w_cmd.command)
                CMD_LOAD: begin
                    w_res_load = 1'b1;
                    if (w_load_wr) begin
                        n_out.segments_left = LEFT_BITS'(r_cnt + 1'b1);
                    end else begin
                        n_out.load_rejected = 1'b1;
                    end
                end
                CMD_PULL: begin
                    if (r_in_contour && r_closing) begin
                        w_res_load         = 1'b1;
                        n_out.point_x      = r_start.x;
                        n_out.point_y      = r_start.y;
                        n_out.point_valid  = 1'b1;
                        n_out.contour_done = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    w_res_load          = 1'b1;
                    n_out.segments_left = '0;
                end
                default: begin
                    w_res_load = 1'b1;
                end
            endcase
        end else if ((r_state == ST_DONE) && w_out_free) begin
            w_res_load = 1'b1;
            if (r_found) begin
                n_out.segments_left = LEFT_BITS'(r_cnt - 1'b1);
                n_out.point_valid   = 1'b1;
            end
            if (!r_in_contour) begin
                if (r_found) begin
                    n_out.point_x = r_hit.a.x;
                    n_out.point_y = r_hit.a.y;
                end else begin
                    n_out.table_empty = 1'b1;
                end
            end else if (r_found) begin
                n_out.point_x = r_cur.x;
                n_out.point_y = r_cur.y;
            end else begin
                n_out.contour_done = 1'b1;
                n_out.contour_open = 1'b1;
            end
        end
        n_out_v = r_out_v;
        if (w_res_load) begin
            n_out_v = 1'b1;
        end else if (r_out_v && o_res.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_k          <= '0;
            r_slot       <= '0;
            r_cnt        <= '0;
            r_start      <= '0;
            r_cur        <= '0;
            r_in_contour <= 1'b0;
            r_closing    <= 1'b0;
            r_found      <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
            if (w_res_load) begin
                r_out <= n_out;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (w_cmd.command)
                            CMD_LOAD: begin
                                if (w_load_wr) begin
                                    r_slot <= r_slot + 1'b1;
                                    r_cnt  <= r_cnt + 1'b1;
                                end
                            end
                            CMD_PULL: begin
                                if (r_in_contour && r_closing) begin
                                    r_in_contour <= 1'b0;
                                    r_closing    <= 1'b0;
                                end else begin
                                    r_state <= ST_SCAN;
                                    r_k     <= '0;
                                    r_found <= 1'b0;
                                end
                            end
                            CMD_CLEAR: begin
                                r_slot       <= '0;
                                r_cnt        <= '0;
                                r_in_contour <= 1'b0;
                                r_closing    <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_hit   <= w_seg[0];
                    end
                    if (r_k == IW'(SEGMENTS - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                        if (r_found) begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                        if (!r_in_contour) begin
                            if (r_found) begin
                                r_start      <= r_hit.a;
                                r_cur        <= r_hit.b;
                                r_in_contour <= 1'b1;
                                r_closing    <= 1'b0;
                            end
                        end else begin
                            if (r_found) begin
                                r_cur     <= w_next;
                                r_closing <= (w_next == r_start);
                            end else begin
                                r_in_contour <= 1'b0;
                                r_closing    <= 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire
